>>> src/point_in_tetrahedron_locator_defines.svh
// Assertion macros used by the checker file of the tetrahedron locator.
`ifndef POINT_IN_TETRAHEDRON_LOCATOR_DEFINES_SVH
`define POINT_IN_TETRAHEDRON_LOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge.
`define PITL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge.
`define PITL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/pitl_pkg.sv
// Shared constants, codes and controller/datapath types of the tetrahedron locator.
`default_nettype none

package pitl_pkg;

   localparam int MAX_TETRAS   = 1024;
   localparam int COORD_BITS   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int WEIGHT_BITS  = 24;
   localparam int OVER_BITS    = 23;
   localparam int TNUM_BITS    = 10;
   localparam int POS_BITS     = 16;

   localparam int CORNER_DEPTH = 4 * MAX_TETRAS;
   localparam int TIDX_W       = (MAX_TETRAS > 1) ? $clog2(MAX_TETRAS) : 1;
   localparam int ADDR_W       = TIDX_W + 2;
   localparam int COUNT_W      = $clog2(MAX_TETRAS + 1);
   localparam int CORNER_W     = 3 * COORD_BITS;

   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int CROSS_W      = 2 * DIFF_W + 1;
   localparam int DET_W        = 3 * DIFF_W + 3;
   localparam int DIV_W        = DET_W + FRAC_BITS + WEIGHT_BITS;
   localparam int DIVC_W       = $clog2(WEIGHT_BITS + 2);
   localparam int SUM_W        = WEIGHT_BITS + 2;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_LOAD   = 2'd1,
      FUNC_LOCATE = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_LOCATED = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FETCH,
      ST_DIFF,
      ST_CROSS,
      ST_DOT,
      ST_DIVINIT,
      ST_DIVSTEP,
      ST_WEIGHT,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              req_ready;
      logic              mem_we;
      logic              mem_re;
      logic [ADDR_W-1:0] mem_addr;
      logic              fetch_cap;
      logic [1:0]        fetch_slot;
      logic              do_diff;
      logic              do_cross;
      logic              do_dot;
      logic              div_init;
      logic              div_step;
      logic              do_weight;
      logic              do_eval;
      logic              eval_first;
      logic [TIDX_W-1:0] scan_idx;
      logic              load_out;
      status_type        res;
   } cmd_type;

   typedef struct packed {
      logic     req_accept;
      func_type func;
      logic     enclosed;
      logic     out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> src/pitl_intf.sv
// Request and response channel interfaces of the tetrahedron locator.
`default_nettype none

interface pitl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            func;
   logic signed [pitl_pkg::POS_BITS-1:0]  pos_x;
   logic signed [pitl_pkg::POS_BITS-1:0]  pos_y;
   logic signed [pitl_pkg::POS_BITS-1:0]  pos_z;

   modport source (output valid, func, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, func, pos_x, pos_y, pos_z, output ready);
endinterface

interface pitl_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              status;
   logic [pitl_pkg::TNUM_BITS-1:0]          tetra_number;
   logic                                    inside_res;
   logic signed [pitl_pkg::WEIGHT_BITS-1:0] bary_a;
   logic signed [pitl_pkg::WEIGHT_BITS-1:0] bary_b;
   logic signed [pitl_pkg::WEIGHT_BITS-1:0] bary_c;
   logic [pitl_pkg::OVER_BITS-1:0]          overshoot;

   modport source (output valid, status, tetra_number, inside_res, bary_a, bary_b, bary_c,
                   overshoot, input ready);
   modport sink   (input valid, status, tetra_number, inside_res, bary_a, bary_b, bary_c,
                   overshoot, output ready);
endinterface

`default_nettype wire

>>> src/pitl_div_lane.sv
// One restoring divider lane that turns a determinant ratio into a saturated weight.
`default_nettype none

module pitl_div_lane (
   input  wire logic                                    clock,
   input  wire logic                                    start,
   input  wire logic                                    step,
   input  wire logic signed [pitl_pkg::DET_W-1:0]       num,
   input  wire logic signed [pitl_pkg::DET_W-1:0]       den,
   output logic signed [pitl_pkg::WEIGHT_BITS-1:0]      weight
);

   localparam int M = pitl_pkg::DET_W;
   localparam int W = pitl_pkg::WEIGHT_BITS;
   localparam int D = pitl_pkg::DIV_W;

   logic [D-1:0] rem_ff, rem_in;
   logic [D-1:0] dsh_ff, dsh_in;
   logic [W:0]   quo_ff, quo_in;
   logic         neg_ff, neg_in;
   logic         degen_ff, degen_in;

   logic [M-1:0] nmag, dmag;
   logic [W-1:0] lim, mag;

   always_comb begin
      nmag     = num[M-1] ? M'(-num) : M'(num);
      dmag     = den[M-1] ? M'(-den) : M'(den);
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      degen_in = degen_ff;
      if (start) begin
         rem_in   = D'(nmag) << pitl_pkg::FRAC_BITS;
         dsh_in   = D'(dmag) << W;
         quo_in   = '0;
         degen_in = (den == '0);
         neg_in   = (den == '0) ? num[M-1] : (num[M-1] ^ den[M-1]);
      end else if (step && !degen_ff) begin
         // The top quotient bit flags an overflow of the weight range.
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[W-1:0], 1'b1};
         end else begin
            quo_in = {quo_ff[W-1:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      degen_ff <= degen_in;
   end

   always_comb begin
      lim = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      if (degen_ff) begin
         mag = (rem_ff > D'(lim)) ? lim : rem_ff[W-1:0];
      end else begin
         mag = (quo_ff[W] || (quo_ff[W-1:0] > lim)) ? lim : quo_ff[W-1:0];
      end
      weight = neg_ff ? signed'(~mag + 1'b1) : signed'(mag);
   end

endmodule

`default_nettype wire

>>> src/pitl_datapath.sv
// Datapath: corner memory, determinant stages, divider lanes, best-candidate and output registers.
`default_nettype none

module pitl_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pitl_pkg::cmd_type cmd,
   output pitl_pkg::sts_type      sts,
   pitl_req_if.sink               req_if,
   pitl_rsp_if.source             rsp_if
);

   localparam int C  = pitl_pkg::COORD_BITS;
   localparam int DW = pitl_pkg::DIFF_W;
   localparam int XW = pitl_pkg::CROSS_W;
   localparam int MW = pitl_pkg::DET_W;
   localparam int W  = pitl_pkg::WEIGHT_BITS;
   localparam int SW = pitl_pkg::SUM_W;
   localparam logic signed [SW-1:0] ONE_Q    = SW'(1 << pitl_pkg::FRAC_BITS);
   localparam logic signed [SW-1:0] OVER_MAX = SW'((1 << pitl_pkg::OVER_BITS) - 1);

   function automatic logic signed [XW-1:0] xterm(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b,
                                                   input logic signed [DW-1:0] c,
                                                   input logic signed [DW-1:0] d);
      logic signed [2*DW-1:0] p1;
      logic signed [2*DW-1:0] p2;
      p1 = a * b;
      p2 = c * d;
      return XW'(p1) - XW'(p2);
   endfunction

   function automatic logic signed [MW-1:0] dot3(input logic signed [DW-1:0] ux,
                                                  input logic signed [DW-1:0] uy,
                                                  input logic signed [DW-1:0] uz,
                                                  input logic signed [XW-1:0] vx,
                                                  input logic signed [XW-1:0] vy,
                                                  input logic signed [XW-1:0] vz);
      logic signed [DW+XW-1:0] px;
      logic signed [DW+XW-1:0] py;
      logic signed [DW+XW-1:0] pz;
      px = ux * vx;
      py = uy * vy;
      pz = uz * vz;
      return MW'(px) + MW'(py) + MW'(pz);
   endfunction

   // Request capture.
   logic [1:0]          func_ff;
   logic signed [C-1:0] px_ff, py_ff, pz_ff;

   always_ff @(posedge clock) begin
      if (sts.req_accept) begin
         func_ff <= req_if.func;
         px_ff   <= C'($unsigned(req_if.pos_x));
         py_ff   <= C'($unsigned(req_if.pos_y));
         pz_ff   <= C'($unsigned(req_if.pos_z));
      end
   end

   // Corner memory with a registered read port.
   logic [pitl_pkg::CORNER_W-1:0] mem [pitl_pkg::CORNER_DEPTH];
   logic [pitl_pkg::CORNER_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[cmd.mem_addr] <= {px_ff, py_ff, pz_ff};
      end
      if (cmd.mem_re) begin
         rd_ff <= mem[cmd.mem_addr];
      end
   end

   logic signed [C-1:0] cx_ff [4];
   logic signed [C-1:0] cy_ff [4];
   logic signed [C-1:0] cz_ff [4];

   always_ff @(posedge clock) begin
      if (cmd.fetch_cap) begin
         cx_ff[cmd.fetch_slot] <= rd_ff[3*C-1:2*C];
         cy_ff[cmd.fetch_slot] <= rd_ff[2*C-1:C];
         cz_ff[cmd.fetch_slot] <= rd_ff[C-1:0];
      end
   end

   // Edge vectors relative to corner 3; slot 3 holds the query point.
   logic signed [DW-1:0] qx_ff [4];
   logic signed [DW-1:0] qy_ff [4];
   logic signed [DW-1:0] qz_ff [4];

   always_ff @(posedge clock) begin
      if (cmd.do_diff) begin
         for (int j = 0; j < 3; j++) begin
            qx_ff[j] <= DW'(cx_ff[j]) - DW'(cx_ff[3]);
            qy_ff[j] <= DW'(cy_ff[j]) - DW'(cy_ff[3]);
            qz_ff[j] <= DW'(cz_ff[j]) - DW'(cz_ff[3]);
         end
         qx_ff[3] <= DW'(px_ff) - DW'(cx_ff[3]);
         qy_ff[3] <= DW'(py_ff) - DW'(cy_ff[3]);
         qz_ff[3] <= DW'(pz_ff) - DW'(cz_ff[3]);
      end
   end

   // Cross products q1 x q2, q3 x q2 and q1 x q3.
   logic signed [XW-1:0] k12x_ff, k12y_ff, k12z_ff;
   logic signed [XW-1:0] k32x_ff, k32y_ff, k32z_ff;
   logic signed [XW-1:0] k13x_ff, k13y_ff, k13z_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_cross) begin
         k12x_ff <= xterm(qy_ff[1], qz_ff[2], qz_ff[1], qy_ff[2]);
         k12y_ff <= xterm(qz_ff[1], qx_ff[2], qx_ff[1], qz_ff[2]);
         k12z_ff <= xterm(qx_ff[1], qy_ff[2], qy_ff[1], qx_ff[2]);
         k32x_ff <= xterm(qy_ff[3], qz_ff[2], qz_ff[3], qy_ff[2]);
         k32y_ff <= xterm(qz_ff[3], qx_ff[2], qx_ff[3], qz_ff[2]);
         k32z_ff <= xterm(qx_ff[3], qy_ff[2], qy_ff[3], qx_ff[2]);
         k13x_ff <= xterm(qy_ff[1], qz_ff[3], qz_ff[1], qy_ff[3]);
         k13y_ff <= xterm(qz_ff[1], qx_ff[3], qx_ff[1], qz_ff[3]);
         k13z_ff <= xterm(qx_ff[1], qy_ff[3], qy_ff[1], qx_ff[3]);
      end
   end

   logic signed [MW-1:0] den_ff, na_ff, nb_ff, nc_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_dot) begin
         den_ff <= dot3(qx_ff[0], qy_ff[0], qz_ff[0], k12x_ff, k12y_ff, k12z_ff);
         na_ff  <= dot3(qx_ff[3], qy_ff[3], qz_ff[3], k12x_ff, k12y_ff, k12z_ff);
         nb_ff  <= dot3(qx_ff[0], qy_ff[0], qz_ff[0], k32x_ff, k32y_ff, k32z_ff);
         nc_ff  <= dot3(qx_ff[0], qy_ff[0], qz_ff[0], k13x_ff, k13y_ff, k13z_ff);
      end
   end

   logic signed [W-1:0] la, lb, lc;

   pitl_div_lane u_div_a (
      .clock(clock), .start(cmd.div_init), .step(cmd.div_step),
      .num(na_ff), .den(den_ff), .weight(la)
   );
   pitl_div_lane u_div_b (
      .clock(clock), .start(cmd.div_init), .step(cmd.div_step),
      .num(nb_ff), .den(den_ff), .weight(lb)
   );
   pitl_div_lane u_div_c (
      .clock(clock), .start(cmd.div_init), .step(cmd.div_step),
      .num(nc_ff), .den(den_ff), .weight(lc)
   );

   logic signed [W-1:0] wa_ff, wb_ff, wc_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_weight) begin
         wa_ff <= la;
         wb_ff <= lb;
         wc_ff <= lc;
      end
   end

   // Inside test and overshoot of the current tetrahedron.
   logic signed [SW-1:0] sum, ov, nega, negb, negc;
   logic                 enclosed;

   always_comb begin
      sum      = SW'(wa_ff) + SW'(wb_ff) + SW'(wc_ff);
      nega     = -SW'(wa_ff);
      negb     = -SW'(wb_ff);
      negc     = -SW'(wc_ff);
      enclosed = !wa_ff[W-1] && !wb_ff[W-1] && !wc_ff[W-1] && (sum <= ONE_Q);
      ov       = '0;
      if (sum > ONE_Q) begin
         ov = sum - ONE_Q;
      end
      if (nega > ov) begin
         ov = nega;
      end
      if (negb > ov) begin
         ov = negb;
      end
      if (negc > ov) begin
         ov = negc;
      end
   end

   logic signed [SW-1:0]             best_ov_ff;
   logic signed [W-1:0]              ba_ff, bb_ff, bc_ff;
   logic [pitl_pkg::TIDX_W-1:0]      bt_ff;
   logic                             bin_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_eval && (enclosed || cmd.eval_first || (ov < best_ov_ff))) begin
         best_ov_ff <= enclosed ? '0 : ov;
         ba_ff      <= wa_ff;
         bb_ff      <= wb_ff;
         bc_ff      <= wc_ff;
         bt_ff      <= cmd.scan_idx;
         bin_ff     <= enclosed;
      end
   end

   // Output register.
   logic                             rvalid_ff;
   logic [1:0]                       rstat_ff;
   logic [pitl_pkg::TNUM_BITS-1:0]   rtn_ff;
   logic                             rin_ff;
   logic signed [W-1:0]              ra_ff, rb_ff, rc_ff;
   logic [pitl_pkg::OVER_BITS-1:0]   rov_ff;
   logic                             located;

   assign located = (cmd.res == pitl_pkg::STAT_LOCATED);

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rvalid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rstat_ff <= cmd.res;
         rtn_ff   <= located ? pitl_pkg::TNUM_BITS'(bt_ff) : '0;
         rin_ff   <= located && bin_ff;
         ra_ff    <= located ? ba_ff : '0;
         rb_ff    <= located ? bb_ff : '0;
         rc_ff    <= located ? bc_ff : '0;
         if (!located) begin
            rov_ff <= '0;
         end else if (best_ov_ff > OVER_MAX) begin
            rov_ff <= OVER_MAX[pitl_pkg::OVER_BITS-1:0];
         end else begin
            rov_ff <= best_ov_ff[pitl_pkg::OVER_BITS-1:0];
         end
      end
   end

   assign req_if.ready        = cmd.req_ready;
   assign rsp_if.valid        = rvalid_ff;
   assign rsp_if.status       = rstat_ff;
   assign rsp_if.tetra_number = rtn_ff;
   assign rsp_if.inside_res   = rin_ff;
   assign rsp_if.bary_a       = ra_ff;
   assign rsp_if.bary_b       = rb_ff;
   assign rsp_if.bary_c       = rc_ff;
   assign rsp_if.overshoot    = rov_ff;

   assign sts.req_accept = req_if.valid && cmd.req_ready;
   assign sts.func       = pitl_pkg::func_type'(func_ff);
   assign sts.enclosed   = enclosed;
   assign sts.out_free   = !rvalid_ff || rsp_if.ready;

endmodule

`default_nettype wire

>>> src/pitl_ctrl.sv
// Controller: table bookkeeping and the per-tetrahedron scan sequence.
`default_nettype none

module pitl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pitl_pkg::sts_type sts,
   output pitl_pkg::cmd_type      cmd
);

   localparam int CW = pitl_pkg::COUNT_W;
   localparam int TW = pitl_pkg::TIDX_W;
   localparam int VW = pitl_pkg::DIVC_W;
   localparam logic [2:0]    FETCH_LAST = 3'd4;
   localparam logic [VW-1:0] DIV_LAST   = VW'(pitl_pkg::WEIGHT_BITS);
   localparam logic [CW-1:0] COUNT_FULL = CW'(pitl_pkg::MAX_TETRAS);

   pitl_pkg::state_type  state_ff, state_in;
   pitl_pkg::status_type res_ff, res_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [1:0]           phase_ff, phase_in;
   logic [TW-1:0]        scan_ff, scan_in;
   logic [2:0]           fc_ff, fc_in;
   logic [VW-1:0]        div_ff, div_in;
   logic                 last_tetra;

   assign last_tetra = (CW'(scan_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pitl_pkg::ST_IDLE: begin
            if (sts.req_accept) begin
               state_in = pitl_pkg::ST_DISPATCH;
            end
         end
         pitl_pkg::ST_DISPATCH: begin
            if (sts.func == pitl_pkg::FUNC_LOCATE && count_ff != '0) begin
               state_in = pitl_pkg::ST_FETCH;
            end else begin
               state_in = pitl_pkg::ST_FINISH;
            end
         end
         pitl_pkg::ST_FETCH: begin
            if (fc_ff == FETCH_LAST) begin
               state_in = pitl_pkg::ST_DIFF;
            end
         end
         pitl_pkg::ST_DIFF:    state_in = pitl_pkg::ST_CROSS;
         pitl_pkg::ST_CROSS:   state_in = pitl_pkg::ST_DOT;
         pitl_pkg::ST_DOT:     state_in = pitl_pkg::ST_DIVINIT;
         pitl_pkg::ST_DIVINIT: state_in = pitl_pkg::ST_DIVSTEP;
         pitl_pkg::ST_DIVSTEP: begin
            if (div_ff == DIV_LAST) begin
               state_in = pitl_pkg::ST_WEIGHT;
            end
         end
         pitl_pkg::ST_WEIGHT:  state_in = pitl_pkg::ST_EVAL;
         pitl_pkg::ST_EVAL: begin
            if (sts.enclosed || last_tetra) begin
               state_in = pitl_pkg::ST_FINISH;
            end else begin
               state_in = pitl_pkg::ST_FETCH;
            end
         end
         pitl_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = pitl_pkg::ST_IDLE;
            end
         end
         default: state_in = pitl_pkg::ST_IDLE;
      endcase
   end

   // Counters and the pending result code.
   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      scan_in  = scan_ff;
      fc_in    = fc_ff;
      div_in   = div_ff;
      res_in   = res_ff;
      unique case (state_ff)
         pitl_pkg::ST_DISPATCH: begin
            scan_in = '0;
            fc_in   = '0;
            unique case (sts.func)
               pitl_pkg::FUNC_CLEAR: begin
                  count_in = '0;
                  phase_in = '0;
                  res_in   = pitl_pkg::STAT_OK;
               end
               pitl_pkg::FUNC_LOAD: begin
                  if (count_ff == COUNT_FULL) begin
                     res_in = pitl_pkg::STAT_FULL;
                  end else begin
                     res_in   = pitl_pkg::STAT_OK;
                     phase_in = phase_ff + 2'd1;
                     if (phase_ff == 2'd3) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
               end
               pitl_pkg::FUNC_LOCATE: begin
                  res_in = (count_ff == '0) ? pitl_pkg::STAT_EMPTY : pitl_pkg::STAT_LOCATED;
               end
               pitl_pkg::FUNC_NOP: res_in = pitl_pkg::STAT_OK;
               default:            res_in = pitl_pkg::STAT_OK;
            endcase
         end
         pitl_pkg::ST_FETCH:   fc_in  = fc_ff + 3'd1;
         pitl_pkg::ST_DIVINIT: div_in = '0;
         pitl_pkg::ST_DIVSTEP: div_in = div_ff + VW'(1);
         pitl_pkg::ST_EVAL: begin
            scan_in = scan_ff + TW'(1);
            fc_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pitl_pkg::ST_IDLE;
         count_ff <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      fc_ff   <= fc_in;
      div_ff  <= div_in;
      res_ff  <= res_in;
   end

   always_comb begin
      cmd            = '0;
      cmd.scan_idx   = scan_ff;
      cmd.res        = res_ff;
      cmd.eval_first = (scan_ff == '0);
      unique case (state_ff)
         pitl_pkg::ST_IDLE: cmd.req_ready = 1'b1;
         pitl_pkg::ST_DISPATCH: begin
            cmd.mem_addr = {count_ff[TW-1:0], phase_ff};
            cmd.mem_we   = (sts.func == pitl_pkg::FUNC_LOAD) && (count_ff != COUNT_FULL);
         end
         pitl_pkg::ST_FETCH: begin
            cmd.mem_addr   = {scan_ff, fc_ff[1:0]};
            cmd.mem_re     = (fc_ff != FETCH_LAST);
            cmd.fetch_cap  = (fc_ff != '0);
            cmd.fetch_slot = fc_ff[1:0] - 2'd1;
         end
         pitl_pkg::ST_DIFF:    cmd.do_diff   = 1'b1;
         pitl_pkg::ST_CROSS:   cmd.do_cross  = 1'b1;
         pitl_pkg::ST_DOT:     cmd.do_dot    = 1'b1;
         pitl_pkg::ST_DIVINIT: cmd.div_init  = 1'b1;
         pitl_pkg::ST_DIVSTEP: cmd.div_step  = 1'b1;
         pitl_pkg::ST_WEIGHT:  cmd.do_weight = 1'b1;
         pitl_pkg::ST_EVAL:    cmd.do_eval   = 1'b1;
         pitl_pkg::ST_FINISH:  cmd.load_out  = sts.out_free;
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/point_in_tetrahedron_locator.sv
// Top level of the point-in-tetrahedron locator.
//
// The req_if channel carries one word per command: func 0 clears the table,
// func 1 stores the next corner (four corners make one tetrahedron), func 2
// locates the point given in pos_x/pos_y/pos_z, and func 3 does nothing.
// Every word accepted on req_if yields exactly one word on rsp_if.
// A clear, a corner load or an unused code passes the dispatch and finish states
// before its result goes to rsp_if; the block returns to idle as it is loaded.
// A locate scans the stored tetrahedra in load order; each one goes through
// 4 corner reads through the single memory port with a registered read port,
// three arithmetic stages and 25 steps of the three parallel restoring dividers
// before its weights are registered and evaluated. The scan ends after the last
// stored tetrahedron, or early when an enclosing tetrahedron is found.
// The block handles one command at a time; req_if.ready is high only while it
// is idle, and it may take a new word while the previous result still waits in
// the output register. If the receiver stalls rsp_if, the next result is held
// internally until the output register frees up.
// Reset empties the table and the load phase; the corner memory itself is not
// cleared and is only ever read at entries that were written.
`default_nettype none

module point_in_tetrahedron_locator (
   input  wire logic  clock,
   input  wire logic  reset,
   pitl_req_if.sink   req_if,
   pitl_rsp_if.source rsp_if
);

   pitl_pkg::cmd_type cmd;
   pitl_pkg::sts_type sts;

   // The controller sequences; the datapath holds all payload state.
   pitl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   pitl_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

>>> src/pitl_checker.sv
// Port-level assertion checker for the tetrahedron locator, with its bind.
`default_nettype none
`include "point_in_tetrahedron_locator_defines.svh"

module pitl_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic [1:0]                             rsp_status,
   input wire logic [pitl_pkg::TNUM_BITS-1:0]         rsp_tetra_number,
   input wire logic                                   rsp_inside_res,
   input wire logic signed [pitl_pkg::WEIGHT_BITS-1:0] rsp_bary_a,
   input wire logic [pitl_pkg::OVER_BITS-1:0]         rsp_overshoot
);

   `PITL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "response word dropped or changed while stalled")
   `PITL_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second request taken while a command is in progress")
   `PITL_ASSERT_IMPLY(a_reset_empty, clock, reset, $fell(reset), !rsp_valid, "response word present right after reset")
   `PITL_ASSERT_IMPLY(a_plain_zero, clock, reset, rsp_valid && rsp_status != pitl_pkg::STAT_LOCATED, rsp_tetra_number == '0 && !rsp_inside_res && rsp_bary_a == '0 && rsp_overshoot == '0, "non-locate answer carries location fields")
   `PITL_ASSERT_IMPLY(a_inside_exact, clock, reset, rsp_valid && rsp_inside_res, rsp_overshoot == '0 && !rsp_bary_a[pitl_pkg::WEIGHT_BITS-1], "enclosing tetrahedron reported with overshoot or negative weight")

endmodule

bind point_in_tetrahedron_locator pitl_checker u_pitl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_tetra_number (rsp_if.tetra_number),
   .rsp_inside_res   (rsp_if.inside_res),
   .rsp_bary_a       (rsp_if.bary_a),
   .rsp_overshoot    (rsp_if.overshoot)
);

`default_nettype wire
